// File: rtl/pidc_pkg.sv
// shared types, reset constants and saturating fixed-point helpers for the pid step
`timescale 1ns / 1ps
`default_nettype none
package pidc_pkg;

   localparam int unsigned RegCount = 8;
   localparam int unsigned AddrWidth = 5;

   typedef enum logic [2:0] {
      REG_PROP_GAIN        = 3'd0,
      REG_INTEGRAL_GAIN    = 3'd1,
      REG_DERIVATIVE_GAIN  = 3'd2,
      REG_DERIVATIVE_DECAY = 3'd3,
      REG_DRIVE_MIN        = 3'd4,
      REG_DRIVE_MAX        = 3'd5,
      REG_ACCUM_MIN        = 3'd6,
      REG_ACCUM_MAX        = 3'd7
   } reg_index_type;

   localparam logic signed [31:0] PropGainReset = 32'sd65536;
   localparam logic signed [31:0] Q32Min = 32'sh8000_0000;
   localparam logic signed [31:0] Q32Max = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [31:0] prop_gain;
      logic signed [31:0] integral_gain;
      logic signed [31:0] derivative_gain;
      logic signed [31:0] derivative_decay;
      logic signed [31:0] drive_min;
      logic signed [31:0] drive_max;
      logic signed [31:0] accum_min;
      logic signed [31:0] accum_max;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] accumulator;
      logic signed [31:0] last_error;
      logic signed [31:0] last_measured;
      logic signed [31:0] filtered_slope;
   } state_type;

   function automatic logic signed [33:0] ext34(input logic signed [31:0] a);
      return {{2{a[31]}}, a};
   endfunction

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = Q32Min;
      end else begin
         r = Q32Max;
      end
      return r;
   endfunction

   // q16.16 product, floor of the shift, saturated
   function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [47:0] q;
      logic signed [31:0] r;
      p = 64'(a) * 64'(b);
      q = p[63:16];
      if (q[47:31] == {17{1'b0}} || q[47:31] == {17{1'b1}}) begin
         r = q[31:0];
      end else if (q[47]) begin
         r = Q32Min;
      end else begin
         r = Q32Max;
      end
      return r;
   endfunction

   // upper limit tested first: with inverted limits, v above hi gives hi, else lo
   function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v,
                                                  input logic signed [31:0] lo,
                                                  input logic signed [31:0] hi);
      logic signed [31:0] r;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/pidc_csr.sv
// apb-style register file holding the gains and clamp limits
`timescale 1ns / 1ps
`default_nettype none
module pidc_csr
   import pidc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic      [31:0]          csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign idx = reg_index_type'(csr_paddr[AddrWidth-1:2]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain        <= PropGainReset;
         cfg_ff.integral_gain    <= '0;
         cfg_ff.derivative_gain  <= '0;
         cfg_ff.derivative_decay <= '0;
         cfg_ff.drive_min        <= Q32Min;
         cfg_ff.drive_max        <= Q32Max;
         cfg_ff.accum_min        <= Q32Min;
         cfg_ff.accum_max        <= Q32Max;
      end else if (wr_en) begin
         unique case (idx)
            REG_PROP_GAIN:        cfg_ff.prop_gain        <= csr_pwdata;
            REG_INTEGRAL_GAIN:    cfg_ff.integral_gain    <= csr_pwdata;
            REG_DERIVATIVE_GAIN:  cfg_ff.derivative_gain  <= csr_pwdata;
            REG_DERIVATIVE_DECAY: cfg_ff.derivative_decay <= csr_pwdata;
            REG_DRIVE_MIN:        cfg_ff.drive_min        <= csr_pwdata;
            REG_DRIVE_MAX:        cfg_ff.drive_max        <= csr_pwdata;
            REG_ACCUM_MIN:        cfg_ff.accum_min        <= csr_pwdata;
            REG_ACCUM_MAX:        cfg_ff.accum_max        <= csr_pwdata;
            default:              cfg_ff.prop_gain        <= cfg_ff.prop_gain;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_PROP_GAIN:        csr_prdata = cfg_ff.prop_gain;
         REG_INTEGRAL_GAIN:    csr_prdata = cfg_ff.integral_gain;
         REG_DERIVATIVE_GAIN:  csr_prdata = cfg_ff.derivative_gain;
         REG_DERIVATIVE_DECAY: csr_prdata = cfg_ff.derivative_decay;
         REG_DRIVE_MIN:        csr_prdata = cfg_ff.drive_min;
         REG_DRIVE_MAX:        csr_prdata = cfg_ff.drive_max;
         REG_ACCUM_MIN:        csr_prdata = cfg_ff.accum_min;
         REG_ACCUM_MAX:        csr_prdata = cfg_ff.accum_max;
         default:              csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/pidc_core.sv
// one-pass pid arithmetic with the controller state registers
`timescale 1ns / 1ps
`default_nettype none
module pidc_core
   import pidc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic signed [31:0] target,
   input  wire logic signed [31:0] measured,
   input  wire cfg_type            cfg,
   output logic signed [31:0]      drive
);

   state_type          state_ff;
   state_type          state_in;
   logic signed [31:0] error, prop, dm, slope, esum, acc_sum, acc;
   logic signed [33:0] drive_sum;

   always_comb begin
      error = sat34(ext34(target) - ext34(measured));
      prop  = mul_q(cfg.prop_gain, error);

      // band-limited derivative on the measurement
      dm    = sat34(ext34(measured) - ext34(state_ff.last_measured));
      slope = sat34(ext34(mul_q(cfg.derivative_decay, state_ff.filtered_slope))
                    - ext34(mul_q(cfg.derivative_gain, dm)));

      // trapezoidal integral with anti-windup clamp
      esum    = sat34(ext34(error) + ext34(state_ff.last_error));
      acc_sum = sat34(ext34(state_ff.accumulator) + ext34(mul_q(cfg.integral_gain, esum)));
      acc     = clamp_q(acc_sum, cfg.accum_min, cfg.accum_max);

      drive_sum = ext34(prop) + ext34(acc) + ext34(slope);
      drive     = clamp_q(sat34(drive_sum), cfg.drive_min, cfg.drive_max);

      state_in.accumulator    = acc;
      state_in.last_error     = error;
      state_in.last_measured  = measured;
      state_in.filtered_slope = slope;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/pid_controller_step.sv
// top level of the pid controller step: input register, datapath, result register
//
// usage: each transfer on the req_ channel carries a setpoint and a measured
// sample in signed q16.16; each produces exactly one clamped drive value on the
// rsp_ channel, in order. the gains and clamp limits sit in an apb-style
// register file on the csr_ port; the user must write them only while the
// block is idle, since the block itself does not enforce it. a request
// passes the input register, then the result register. throughput: one
// item per cycle while rsp_stall is low, set by the state update, whose
// feedback runs through the decay multiplier of the derivative filter.
// reset clears the controller state, loads the register defaults and empties
// both stages. when rsp_stall is high the result holds; the input stage keeps
// accepting until it too is full, then req_stall follows rsp_stall.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_step
   import pidc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [31:0]   req_target,
   input  wire logic signed [31:0]   req_measured,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [31:0]        rsp_drive,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [AddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic      [31:0]          csr_prdata,
   output logic                      csr_pready
);

   cfg_type            cfg;
   logic               in_valid_ff;
   logic signed [31:0] target_ff, measured_ff;
   logic               out_valid_ff;
   logic signed [31:0] drive_ff;
   logic signed [31:0] drive_in;
   logic               out_free, advance, take;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign take      = req_valid & ~req_stall;

   pidc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .target   (target_ff),
      .measured (measured_ff),
      .cfg      (cfg),
      .drive    (drive_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         target_ff   <= req_target;
         measured_ff <= req_measured;
      end
      if (advance) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_drive = drive_ff;

endmodule
`default_nettype wire

// File: test/pid_controller_step_test.sv
// self-checking testbench for the pid controller step: directed table, then random settings
`timescale 1ns / 1ps
module pid_controller_step_test
   import pidc_pkg::*;
();

   localparam int DrainCycles = 6;
   localparam int IdleLimit = 3000;
   localparam int RandomSettings = 11;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      reg_index_type      idx;
      logic signed [31:0] target;
      logic signed [31:0] measured;
      logic               has_want;
      logic signed [31:0] want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [31:0]   req_target;
   logic signed [31:0]   req_measured;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [31:0]   rsp_drive;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [AddrWidth-1:0] csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   // controller registers and state as the predictor sees them
   logic signed [31:0] ctl_regs [RegCount];
   logic signed [31:0] integ_state, prev_error, prev_measured, slope_state;

   logic signed [31:0] drive_queue [$];
   stim_row_type       stim_rows [$];
   int                 error_count = 0;
   int                 items_sent = 0;
   int                 drives_checked = 0;
   int                 settings_used = 0;
   int                 gap_pct = 30;
   int                 idle_cycles = 0;

   pid_controller_step dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_target   (req_target),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [31:0] fx_sat(input longint v);
      if (v > longint'(Q32Max)) begin
         return Q32Max;
      end else if (v < longint'(Q32Min)) begin
         return Q32Min;
      end
      return v[31:0];
   endfunction

   // arithmetic shift of the 64-bit product rounds toward minus infinity
   function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return fx_sat(p >>> 16);
   endfunction

   function automatic logic signed [31:0] fx_limit(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic logic signed [31:0] step_controller(input logic signed [31:0] target,
                                                          input logic signed [31:0] measured);
      logic signed [31:0] err, prop, dm, slope, esum, acc, drive;
      err = fx_sat(longint'(target) - longint'(measured));
      prop = fx_mul(ctl_regs[REG_PROP_GAIN], err);
      dm = fx_sat(longint'(measured) - longint'(prev_measured));
      slope = fx_sat(longint'(fx_mul(ctl_regs[REG_DERIVATIVE_DECAY], slope_state))
                     - longint'(fx_mul(ctl_regs[REG_DERIVATIVE_GAIN], dm)));
      esum = fx_sat(longint'(err) + longint'(prev_error));
      acc = fx_sat(longint'(integ_state) + longint'(fx_mul(ctl_regs[REG_INTEGRAL_GAIN], esum)));
      acc = fx_limit(acc, ctl_regs[REG_ACCUM_MIN], ctl_regs[REG_ACCUM_MAX]);
      drive = fx_sat(longint'(prop) + longint'(acc) + longint'(slope));
      drive = fx_limit(drive, ctl_regs[REG_DRIVE_MIN], ctl_regs[REG_DRIVE_MAX]);
      integ_state = acc;
      slope_state = slope;
      prev_error = err;
      prev_measured = measured;
      return drive;
   endfunction

   function automatic void add_item(input logic signed [31:0] target,
                                    input logic signed [31:0] measured,
                                    input logic has_want = 1'b0,
                                    input logic signed [31:0] want = 32'sd0);
      stim_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.target = target;
      row.measured = measured;
      row.has_want = has_want;
      row.want = want;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_write(input reg_index_type idx, input logic signed [31:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.idx = idx;
      row.target = value;
      stim_rows.push_back(row);
   endfunction

   function automatic logic signed [31:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return Q32Min;
         1: return Q32Max;
         2: return 32'sd0;
         3: return $urandom;
         default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_sample(input logic signed [31:0] near);
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return Q32Min;
               1: return Q32Max;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3: return $urandom;
         default: return fx_sat(longint'(near) + $urandom_range(0, 1 << 19) - (1 << 18));
      endcase
   endfunction

   task automatic pick_limits(output logic signed [31:0] lo, output logic signed [31:0] hi);
      case ($urandom_range(0, 9))
         0: begin
            lo = Q32Min;
            hi = Q32Max;
         end
         1: begin
            // inverted pair
            lo = $urandom_range(1, 1 << 22);
            hi = -$signed($urandom_range(0, 1 << 22));
         end
         2: begin
            lo = $urandom;
            hi = $urandom;
         end
         default: begin
            lo = -$signed($urandom_range(0, 1 << 22));
            hi = $urandom_range(0, 1 << 22);
         end
      endcase
   endtask

   task automatic write_reg(input reg_index_type idx, input logic signed [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ctl_regs[idx] = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(input logic signed [31:0] target, input logic signed [31:0] measured,
                            input logic has_want, input logic signed [31:0] want);
      logic signed [31:0] predicted;
      req_valid <= 1'b1;
      req_target <= target;
      req_measured <= measured;
      do @(posedge clock); while (req_stall);
      predicted = step_controller(target, measured);
      drive_queue.push_back(has_want ? want : predicted);
      items_sent++;
   endtask

   task automatic pause_sender();
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct) begin
         case ($urandom_range(0, 19))
            0: gap = $urandom_range(20, 50);
            1, 2: gap = $urandom_range(4, 15);
            default: gap = $urandom_range(1, 3);
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // block idle: no request pending, all drives back, pipeline flushed
   task automatic settle();
      req_valid <= 1'b0;
      while (drive_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // result side: random stall bursts with quiet stretches between
   initial begin
      int n;
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         case ($urandom_range(0, 19))
            0: n = $urandom_range(20, 60);
            1, 2, 3: n = $urandom_range(4, 12);
            default: n = $urandom_range(1, 3);
         endcase
         rsp_stall <= 1'b1;
         repeat (n) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_queue.size() == 0) begin
            $error("drive transfer with no expectation pending: got %0d", rsp_drive);
            error_count++;
         end else begin
            want = drive_queue.pop_front();
            drives_checked++;
            if (rsp_drive !== want) begin
               $error("drive mismatch: expected %0d, actual %0d", want, rsp_drive);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no transfer for %0d cycles, %0d drives pending",
               IdleLimit, drive_queue.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic signed [31:0] lo, hi, tgt, meas;
      int n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_target <= '0;
      req_measured <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      ctl_regs[REG_PROP_GAIN] = PropGainReset;
      ctl_regs[REG_INTEGRAL_GAIN] = 32'sd0;
      ctl_regs[REG_DERIVATIVE_GAIN] = 32'sd0;
      ctl_regs[REG_DERIVATIVE_DECAY] = 32'sd0;
      ctl_regs[REG_DRIVE_MIN] = Q32Min;
      ctl_regs[REG_DRIVE_MAX] = Q32Max;
      ctl_regs[REG_ACCUM_MIN] = Q32Min;
      ctl_regs[REG_ACCUM_MAX] = Q32Max;
      integ_state = '0;
      prev_error = '0;
      prev_measured = '0;
      slope_state = '0;

      // reset defaults: unit gain, no integral or derivative, so drive is the saturated error
      add_item(32'sd0, 32'sd0, 1'b1, 32'sd0);
      add_item(Q32Max, Q32Min, 1'b1, Q32Max);
      add_item(Q32Min, Q32Max, 1'b1, Q32Min);
      add_item(Q32Min, Q32Min, 1'b1, 32'sd0);
      add_item(Q32Max, Q32Max, 1'b1, 32'sd0);
      add_item(32'sh0001_0000, 32'sd0, 1'b1, 32'sh0001_0000);
      add_item(32'sd0, 32'sd1, 1'b1, -32'sd1);
      // huge gains: products saturate, decay feeds back with positive sign
      add_write(REG_PROP_GAIN, Q32Max);
      add_write(REG_INTEGRAL_GAIN, 32'sh0000_8000);
      add_write(REG_DERIVATIVE_GAIN, 32'sh0001_0000);
      add_write(REG_DERIVATIVE_DECAY, 32'sh0000_8000);
      add_write(REG_DRIVE_MIN, Q32Min);
      add_write(REG_DRIVE_MAX, Q32Max);
      add_write(REG_ACCUM_MIN, Q32Min);
      add_write(REG_ACCUM_MAX, Q32Max);
      add_item(Q32Max, Q32Min);
      add_item(32'sh0001_0000, 32'sh0003_0000);
      add_item(-32'sd5, 32'sd3);
      add_item(32'sd0, Q32Min);
      add_item(32'sd0, Q32Max);
      // inverted limits on both clamps, most negative gains
      add_write(REG_PROP_GAIN, Q32Min);
      add_write(REG_INTEGRAL_GAIN, Q32Min);
      add_write(REG_DERIVATIVE_GAIN, Q32Min);
      add_write(REG_DERIVATIVE_DECAY, Q32Min);
      add_write(REG_DRIVE_MIN, 32'sh1000_0000);
      add_write(REG_DRIVE_MAX, -32'sh1000_0000);
      add_write(REG_ACCUM_MIN, 32'sh0100_0000);
      add_write(REG_ACCUM_MAX, -32'sh0100_0000);
      add_item(Q32Max, Q32Min);
      add_item(Q32Min, Q32Max);
      add_item(32'sd0, 32'sd0);
      add_item(32'sd12345, -32'sd678);
      // narrow limits: integrator winds up against its clamp
      add_write(REG_PROP_GAIN, 32'sh0001_0000);
      add_write(REG_INTEGRAL_GAIN, 32'sh0000_4000);
      add_write(REG_DERIVATIVE_GAIN, 32'sh0002_0000);
      add_write(REG_DERIVATIVE_DECAY, 32'sh0000_e000);
      add_write(REG_DRIVE_MIN, -32'sh0002_0000);
      add_write(REG_DRIVE_MAX, 32'sh0002_0000);
      add_write(REG_ACCUM_MIN, -32'sh0001_0000);
      add_write(REG_ACCUM_MAX, 32'sh0001_0000);
      add_item(32'sh0005_0000, 32'sd0);
      add_item(32'sh0005_0000, 32'sd0);
      add_item(32'sh0005_0000, 32'sd0);
      add_item(32'sd0, 32'sh0000_8000);
      add_item(-32'sh0005_0000, 32'sd0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      settings_used = 1;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_WRITE) begin
            if (i == 0 || stim_rows[i - 1].kind != ROW_WRITE) begin
               settle();
               settings_used++;
            end
            write_reg(stim_rows[i].idx, stim_rows[i].target);
         end else begin
            send_item(stim_rows[i].target, stim_rows[i].measured,
                      stim_rows[i].has_want, stim_rows[i].want);
            pause_sender();
         end
      end

      for (int s = 0; s < RandomSettings; s++) begin
         settle();
         settings_used++;
         write_reg(REG_PROP_GAIN, pick_gain());
         write_reg(REG_INTEGRAL_GAIN, pick_gain());
         write_reg(REG_DERIVATIVE_GAIN, pick_gain());
         write_reg(REG_DERIVATIVE_DECAY, pick_gain());
         pick_limits(lo, hi);
         write_reg(REG_DRIVE_MIN, lo);
         write_reg(REG_DRIVE_MAX, hi);
         pick_limits(lo, hi);
         write_reg(REG_ACCUM_MIN, lo);
         write_reg(REG_ACCUM_MAX, hi);
         case ($urandom_range(0, 3))
            0: gap_pct = 0;
            1: gap_pct = 20;
            2: gap_pct = 50;
            default: gap_pct = 80;
         endcase
         tgt = pick_sample(32'sd0);
         meas = tgt;
         n = $urandom_range(100, 200);
         repeat (n) begin
            tgt = pick_sample(tgt);
            meas = pick_sample(meas + ((tgt - meas) >>> 3));
            send_item(tgt, meas, 1'b0, 32'sd0);
            pause_sender();
         end
      end

      settle();
      $display("%0d samples sent under %0d register settings, %0d drive values compared",
               items_sent, settings_used, drives_checked);
      $display("covered saturating error and products, inverted clamps and integrator windup");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
